// ===== design/bfaq_pkg.sv =====
// bloom filter add/query package: state codes, action codes, hash constants
// no dependencies
package bfaq_pkg;

  localparam logic [63:0] GOLDEN    = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SEED_STEP = 64'h0000_0100_0000_01B3;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  localparam logic REG_BIT_COUNT  = 1'b0;
  localparam logic REG_HASH_COUNT = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_MOD,
    S_RMW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [16:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] rem;
  } mod_rsp_t;

endpackage

// ===== design/bfaq_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module bfaq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bfaq_mod.sv =====
// bit-serial remainder unit: 64-bit dividend modulo a 17-bit divisor
// the dividend is shifted in one bit at a time, then done is raised; depends on bfaq_pkg
module bfaq_mod import bfaq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [6:0]  count;
  logic [63:0] quot;
  logic [16:0] divisor;
  logic [17:0] rem;
  logic [17:0] trial;
  logic [17:0] rem_next;

  always_comb begin
    trial    = {rem[16:0], quot[63]};
    rem_next = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot    <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      quot <= {quot[62:0], 1'b0};
      rem  <= rem_next;
    end
  end

  assign rsp = '{done: done, rem: rem[16:0]};

endmodule

// ===== design/bloom_filter_add_query.sv =====
// bloom filter add/query engine, top level
// depends on bfaq_pkg, bfaq_ram, bfaq_mod
// a key byte that is not last, a load or a stray item is taken in idle and the engine
// stays ready; a key end holds the input while, for each of nh hashes (nh the clamped
// hash count, zero when disabled), a start state, the bit-serial remainder unit and
// one read-modify-write of the bit store run in order; the result is then loaded into
// the output register from the done state, later while an earlier result still waits
// synchronous reset; afterwards a clearing pass zeroes every byte of the bit store,
// during which no item is taken (config writes still are)
module bloom_filter_add_query import bfaq_pkg::*; #(
  parameter int FILTER_BITS = 65536,
  parameter int MAX_HASHES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [16:0] wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // key_byte[7:0], key_length[23:8], store_address[36:24], store_byte[44:37]
  input  logic [47:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // might_contain[0]
  output logic [7:0]  m_tdata,
  // was_query[0]
  output logic        m_tuser
);

  localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int IW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam logic [20:0] FB = 21'(FILTER_BITS);
  localparam logic [4:0]  MH = 5'(MAX_HASHES);

  logic [16:0] filter_nbits;
  logic [3:0]  filter_nhashes;

  state_t state, state_next;

  logic [63:0] hash [MAX_HASHES];
  logic        key_in_progress;
  logic        act_query;
  logic        hit;
  logic [16:0] nbits;
  logic [4:0]  nh;
  logic [4:0]  idx;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] rmw_addr;
  logic [7:0]    rmw_mask;

  logic [7:0]  key_byte;
  logic [15:0] key_length;
  logic [12:0] store_address;
  logic [7:0]  store_byte;
  logic        in_xfer;
  logic        key_xfer;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic [AW+12:0] load_ext;
  logic [AW+16:0] rem_ext;
  logic [16:0]    nbits_cur;
  logic [4:0]     nh_cur;
  logic           out_load;

  assign key_byte      = s_tdata[7:0];
  assign key_length    = s_tdata[23:8];
  assign store_address = s_tdata[36:24];
  assign store_byte    = s_tdata[44:37];

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign key_xfer = in_xfer && (s_tuser == ACT_ADD || s_tuser == ACT_QUERY);

  assign nbits_cur = ({4'd0, filter_nbits} > FB) ? FB[16:0] : filter_nbits;
  assign nh_cur    = ({1'b0, filter_nhashes} > MH) ? MH : {1'b0, filter_nhashes};

  assign load_ext = {{AW{1'b0}}, store_address};
  assign rem_ext  = {{AW{1'b0}}, mod_rsp.rem};

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_nbits   <= 17'd64;
      filter_nhashes <= 4'd7;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BIT_COUNT:  filter_nbits   <= wr_data;
        REG_HASH_COUNT: filter_nhashes <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // one hash lane per seed
  for (genvar g = 0; g < MAX_HASHES; g++) begin : g_lane
    localparam logic [63:0] SEED = 64'(GOLDEN + 64'(g) * SEED_STEP);
    logic [63:0] base;
    logic [63:0] mixed;
    always_comb begin
      base  = key_in_progress ? hash[g] : (SEED ^ (GOLDEN + {48'd0, key_length}));
      mixed = base ^ ({56'd0, key_byte} + GOLDEN + (base << 6) + (base >> 2));
    end
    always_ff @(posedge clk) begin
      if (key_xfer) begin
        hash[g] <= (key_in_progress || key_length != 16'd0) ? mixed : base;
      end
    end
  end

  always_comb begin
    mod_req.start    = (state == S_START);
    mod_req.dividend = hash[idx[IW-1:0]];
    mod_req.divisor  = nbits;
  end

  bfaq_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_comb begin
    ram_raddr = rem_ext[AW+2:3];
    ram_we    = 1'b0;
    ram_waddr = rmw_addr;
    ram_wdata = ram_rdata | rmw_mask;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 8'd0;
      end
      S_IDLE: begin
        ram_we    = in_xfer && s_tuser == ACT_LOAD &&
                    load_ext < (AW+13)'(STORE_BYTES);
        ram_waddr = load_ext[AW-1:0];
        ram_wdata = store_byte;
      end
      S_RMW: ram_we = !act_query;
      default: ;
    endcase
  end

  bfaq_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == AW'(STORE_BYTES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (key_xfer && s_tlast) begin
          state_next = (nbits_cur == 17'd0 || nh_cur == 5'd0) ? S_DONE : S_START;
        end
      end
      S_START: state_next = S_MOD;
      S_MOD:   if (mod_rsp.done) state_next = S_RMW;
      S_RMW:   state_next = (idx + 5'd1 == nh) ? S_DONE : S_START;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr        <= '0;
      key_in_progress <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (key_xfer) begin
        key_in_progress <= !s_tlast;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_xfer && s_tlast) begin
      act_query <= (s_tuser == ACT_QUERY);
      nbits     <= nbits_cur;
      nh        <= nh_cur;
      idx       <= 5'd0;
      hit       <= 1'b1;
    end
    if (state == S_MOD && mod_rsp.done) begin
      rmw_addr <= ram_raddr;
      rmw_mask <= 8'(1) << mod_rsp.rem[2:0];
    end
    if (state == S_RMW) begin
      idx <= idx + 5'd1;
      if (act_query && (ram_rdata & rmw_mask) == 8'd0) begin
        hit <= 1'b0;
      end
    end
    if (out_load) begin
      m_tdata <= {7'd0, act_query ? hit : 1'b0};
      m_tuser <= act_query;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD || state == S_RMW || state == S_CLEAR) |-> !s_tready)
    else $error("input taken while busy");

  a_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> state == S_MOD)
    else $error("remainder finished outside modulo state");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RMW |-> idx < nh)
    else $error("hash index past hash count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule
